@@ rtl/core/life_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package life_pkg;

  // Grid size defaults
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 64;

  // Field and register widths
  localparam int CMD_W     = 2;
  localparam int ROW_IDX_W = 5;
  localparam int COL_IDX_W = 6;
  localparam int ROWS_W    = 6;
  localparam int COLS_W    = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register reset values
  localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd20;
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd40;

  // Register select, taken from the word address bit of paddr
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_DONE,
    ST_ADV_CUR,
    ST_ADV_NEXT,
    ST_ADV_WRITE
  } ctrl_state_t;

  // Row address source for the grid read port
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_FIRST,
    RD_AHEAD1,
    RD_AHEAD2
  } rd_src_t;

  typedef struct packed {
    logic    latch_item;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_cell;
    logic    wr_row;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    clr_above;
    logic    ld_cur;
    logic    ld_below;
    logic    shift_window;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic region_empty;
    logic below_exists;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/life_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module life_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/life_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module life_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [life_pkg::CMD_W-1:0]    cmd,
  input  life_pkg::dp_status_t          status,
  output life_pkg::ctrl_cmd_t           ctrl
);

  import life_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.rd_src = RD_ITEM;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctrl.latch_item = 1'b1;
          case (cmd)
            CMD_WRITE: begin
              if (status.in_grid) begin
                ctrl.rd_en = 1'b1;
                state_next = ST_WR_MOD;
              end
            end
            CMD_READ: begin
              ctrl.rd_en = status.in_grid;
              state_next = ST_RD_DONE;
            end
            CMD_ADVANCE: begin
              if (!status.region_empty) begin
                ctrl.ptr_clr   = 1'b1;
                ctrl.clr_above = 1'b1;
                ctrl.rd_en     = 1'b1;
                ctrl.rd_src    = RD_FIRST;
                state_next     = ST_ADV_CUR;
              end
            end
            default: begin
              // unused command code: drop the transaction
            end
          endcase
        end
      end
      ST_WR_MOD: begin
        ctrl.wr_cell = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_RD_DONE: begin
        if (status.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_ADV_CUR: begin
        ctrl.ld_cur = 1'b1;
        ctrl.rd_en  = status.below_exists;
        ctrl.rd_src = RD_AHEAD1;
        state_next  = ST_ADV_NEXT;
      end
      ST_ADV_NEXT: begin
        ctrl.ld_below = 1'b1;
        state_next    = ST_ADV_WRITE;
      end
      ST_ADV_WRITE: begin
        ctrl.wr_row       = 1'b1;
        ctrl.shift_window = 1'b1;
        ctrl.ptr_inc      = 1'b1;
        if (status.below_exists) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_src = RD_AHEAD2;
          state_next  = ST_ADV_NEXT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/life_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module life_dpath #(
  parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  life_pkg::ctrl_cmd_t               ctrl,
  output life_pkg::dp_status_t              status,
  input  logic [life_pkg::ROW_IDX_W-1:0]    row_index,
  input  logic [life_pkg::COL_IDX_W-1:0]    col_index,
  input  logic                              cell_in,
  input  logic [life_pkg::ROWS_W-1:0]       rows_in_use,
  input  logic [life_pkg::COLS_W-1:0]       cols_in_use,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              cell_out
);

  import life_pkg::*;

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [RCW-1:0]      nr;
  logic [CCW-1:0]      nc;
  logic [MAX_COLS-1:0] colmask;
  logic [RCW-1:0]      row_ptr;

  logic [RAW-1:0]      row_q;
  logic [CAW-1:0]      col_q;
  logic                cell_q;
  logic                in_grid_q;

  logic [MAX_ROWS-1:0] row_vld;
  logic                rd_vld_q;
  logic [RAW-1:0]      rd_addr;
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] row_data;
  logic                wr_en;
  logic [RAW-1:0]      wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [MAX_COLS-1:0] cell_row;

  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] cur;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS+1:0] pad_a;
  logic [MAX_COLS+1:0] pad_m;
  logic [MAX_COLS+1:0] pad_b;
  logic [3:0]          nbr_cnt [MAX_COLS];
  logic [MAX_COLS-1:0] new_row;

  // Clamp the active region to the grid size
  always_comb begin
    nr = (int'(rows_in_use) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_in_use);
    nc = (int'(cols_in_use) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_in_use);
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = (c < int'(nc));
    end
  end

  assign status.in_grid      = (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
  assign status.region_empty = (nr == '0);
  assign status.below_exists = (int'(row_ptr) + 1 < int'(nr));
  assign status.out_free     = !out_valid || out_ready;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (ctrl.latch_item) begin
      row_q     <= RAW'(row_index);
      col_q     <= CAW'(col_index);
      cell_q    <= cell_in;
      in_grid_q <= status.in_grid;
    end
  end

  // Row pointer of the generation sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ptr <= '0;
    end else if (ctrl.ptr_clr) begin
      row_ptr <= '0;
    end else if (ctrl.ptr_inc) begin
      row_ptr <= row_ptr + RCW'(1);
    end
  end

  // Select the read row
  always_comb begin
    case (ctrl.rd_src)
      RD_ITEM:   rd_addr = RAW'(row_index);
      RD_FIRST:  rd_addr = '0;
      RD_AHEAD1: rd_addr = RAW'(row_ptr + RCW'(1));
      RD_AHEAD2: rd_addr = RAW'(row_ptr + RCW'(2));
      default:   rd_addr = '0;
    endcase
  end

  // Row valid bits: a row never written reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_vld_q <= row_vld[rd_addr];
    end
  end

  assign row_data = rd_vld_q ? rd_data : '0;

  // Single cell update of the fetched row
  always_comb begin
    cell_row        = row_data;
    cell_row[col_q] = cell_q;
  end

  assign wr_en   = ctrl.wr_cell || ctrl.wr_row;
  assign wr_addr = ctrl.wr_cell ? row_q : RAW'(row_ptr);
  assign wr_data = ctrl.wr_cell ? cell_row : new_row;

  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Three-row window over the grid
  always_ff @(posedge clk) begin
    if (ctrl.clr_above) begin
      above <= '0;
    end else if (ctrl.shift_window) begin
      above <= cur;
    end
    if (ctrl.ld_cur) begin
      cur <= row_data;
    end else if (ctrl.shift_window) begin
      cur <= below;
    end
    if (ctrl.ld_below) begin
      below <= status.below_exists ? row_data : '0;
    end
  end

  // Apply B3/S23 to every column of the window; inactive columns keep their value
  always_comb begin
    pad_a = {1'b0, above & colmask, 1'b0};
    pad_m = {1'b0, cur & colmask, 1'b0};
    pad_b = {1'b0, below & colmask, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr_cnt[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                 + 4'(pad_m[c]) + 4'(pad_m[c+2])
                 + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
      if (colmask[c]) begin
        new_row[c] = (nbr_cnt[c] == 4'd3) || (cur[c] && (nbr_cnt[c] == 4'd2));
      end else begin
        new_row[c] = cur[c];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      cell_out <= in_grid_q && row_data[col_q];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/life_automaton_step.sv @@
// Write item: read-modify-write of a grid row; the row is read on acceptance and written back in the cycle after.
// Read item: result registered in ST_RD_DONE once the output register is free; next item taken after that.
// Advance item: sweeps the R active rows in order, R the clamped active row count; each new row is
//   written in ST_ADV_WRITE through the row memory's write port while the next row is read on its read port.
// Reset: synchronous; per-row valid bits clear so the grid reads all dead at once,
//   with no clearing pass; rows_in_use = 20, cols_in_use = 40.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_step #(
  parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,  // row_index[4:0], col_index[10:5], cell_in[11]
  input  logic [life_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // cell_out[0]
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [life_pkg::PADDR_W-1:0]   paddr,
  input  logic [life_pkg::PDATA_W-1:0]   pwdata,
  output logic [life_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import life_pkg::*;

  logic [ROWS_W-1:0]    rows_in_use;
  logic [COLS_W-1:0]    cols_in_use;
  logic                 cfg_wr;
  logic                 cell_out;
  ctrl_cmd_t            ctrl;
  dp_status_t           status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROWS: rows_in_use <= pwdata[ROWS_W-1:0];
        REG_COLS: cols_in_use <= pwdata[COLS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = PDATA_W'(rows_in_use);
      REG_COLS: prdata = PDATA_W'(cols_in_use);
      default:  prdata = '0;
    endcase
  end

  life_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (s_tuser),
    .status   (status),
    .ctrl     (ctrl)
  );

  life_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .row_index   (s_tdata[4:0]),
    .col_index   (s_tdata[10:5]),
    .cell_in     (s_tdata[11]),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .cell_out    (cell_out)
  );

  assign m_tdata = {7'b0, cell_out};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import life_pkg::*;

  // command code the block ignores
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 80;

  // Shadow of the cell grid: predicts every cell_out and checks it in order
  class grid_shadow;
    bit cells [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic [ROWS_W-1:0] rows_cfg;
    logic [COLS_W-1:0] cols_cfg;
    bit pending_cells [$];
    int mismatches;

    function new();
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      mismatches = 0;
      foreach (cells[r, c]) cells[r][c] = 1'b0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function int active_rows();
      return (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg);
    endfunction

    function int active_cols();
      return (cols_cfg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_cfg);
    endfunction

    // B3/S23 inside the active region; cells past its edge count as dead
    function void step_generation();
      bit fresh [MAX_ROWS_DEF][MAX_COLS_DEF];
      int nr, nc, n, rr, cc;
      nr = active_rows();
      nc = active_cols();
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                n += cells[rr][cc];
            end
          end
          fresh[r][c] = cells[r][c] ? (n == 2 || n == 3) : (n == 3);
        end
      end
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          cells[r][c] = fresh[r][c];
    endfunction

    function void apply_item(logic [CMD_W-1:0] cmd, logic [ROW_IDX_W-1:0] row,
                             logic [COL_IDX_W-1:0] col, logic val);
      case (cmd)
        CMD_WRITE: begin
          cells[row][col] = val;
        end
        CMD_ADVANCE: begin
          step_generation();
        end
        CMD_READ: begin
          pending_cells.push_back(cells[row][col]);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_cell(logic got);
      bit want;
      if (pending_cells.size() == 0) begin
        flag($sformatf("cell_out=%0b arrived with no read waiting", got));
      end else begin
        want = pending_cells.pop_front();
        if (got !== want)
          flag($sformatf("cell_out mismatch: expected %0b, got %0b", want, got));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;  // row_index[4:0], col_index[10:5], cell_in[11]
  logic [CMD_W-1:0] s_tuser;  // cmd[1:0]
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;  // cell_out[0]
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic calm;
  grid_shadow shadow;

  life_automaton_step dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both streams at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        shadow.apply_item(s_tuser, s_tdata[4:0], s_tdata[10:5], s_tdata[11]);
      if (m_tvalid && m_tready)
        shadow.check_cell(m_tdata[0]);
    end
  end

  // Result side: random stall bursts until the quiet tail
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        m_tready = 1'b1;
      end else if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        stall = $urandom_range(0, 6);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Hold valid until the transaction is taken; return at the next falling edge
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ROW_IDX_W-1:0] row,
                           logic [COL_IDX_W-1:0] col, logic val);
    s_tuser = cmd;
    s_tdata = {4'b0000, val, col, row};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic feed(logic [CMD_W-1:0] cmd, logic [ROW_IDX_W-1:0] row,
                      logic [COL_IDX_W-1:0] col, logic val);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid = 1'b0;
      s_tdata = 16'($urandom);
      s_tuser = CMD_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    send_item(cmd, row, col, val);
  endtask

  // Stop sending, wait for every read to come back, let a sweep finish
  task automatic drain();
    s_tvalid = 1'b0;
    while (shadow.pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic sel, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] got;
    // setup and access phases of the write
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    if (sel == REG_ROWS) shadow.rows_cfg = value[ROWS_W-1:0];
    else shadow.cols_cfg = value[COLS_W-1:0];
    // read it back
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (sel == REG_ROWS && got[ROWS_W-1:0] !== value[ROWS_W-1:0])
      shadow.flag($sformatf("rows_in_use read back %0d, expected %0d",
                            got[ROWS_W-1:0], value[ROWS_W-1:0]));
    if (sel == REG_COLS && got[COLS_W-1:0] !== value[COLS_W-1:0])
      shadow.flag($sformatf("cols_in_use read back %0d, expected %0d",
                            got[COLS_W-1:0], value[COLS_W-1:0]));
  endtask

  // Mostly writes and reads aimed at the active region, with generations between
  task automatic random_item();
    int nr, nc, pick;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    nr = shadow.active_rows();
    nc = shadow.active_cols();
    row = (nr > 0 && $urandom_range(0, 9) < 8) ? ROW_IDX_W'($urandom_range(0, nr - 1))
                                               : ROW_IDX_W'($urandom_range(0, 31));
    col = (nc > 0 && $urandom_range(0, 9) < 8) ? COL_IDX_W'($urandom_range(0, nc - 1))
                                               : COL_IDX_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 45) feed(CMD_WRITE, row, col, $urandom_range(0, 99) < 40);
    else if (pick < 55) feed(CMD_ADVANCE, row, col, 1'($urandom));
    else if (pick < 96) feed(CMD_READ, row, col, 1'($urandom));
    else feed(CMD_NONE, row, col, 1'($urandom));
  endtask

  // Run limit
  initial begin
    #2000000;
    $display("[life_automaton_step] ERROR");
    $finish;
  end

  initial begin
    logic [ROWS_W-1:0] rows_plan [8];
    logic [COLS_W-1:0] cols_plan [8];
    shadow = new();
    rows_plan = '{6'd20, 6'd0, 6'd32, 6'd63, 6'd1, 6'd3, 6'd32, 6'd17};
    cols_plan = '{7'd40, 7'd64, 7'd0, 7'd127, 7'd1, 7'd5, 7'd64, 7'd33};
    calm = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_WRITE;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fresh grid reads dead at both corners; ignored command leaves it alone
    feed(CMD_READ, 5'd0, 6'd0, 1'b0);
    feed(CMD_READ, 5'd31, 6'd63, 1'b1);
    feed(CMD_NONE, 5'd31, 6'd63, 1'b1);
    feed(CMD_READ, 5'd31, 6'd63, 1'b0);
    // Cell outside the region, lone cell on the region corner, blinker, corner L
    feed(CMD_WRITE, 5'd31, 6'd63, 1'b1);
    feed(CMD_WRITE, 5'd19, 6'd39, 1'b1);
    feed(CMD_WRITE, 5'd5, 6'd4, 1'b1);
    feed(CMD_WRITE, 5'd5, 6'd5, 1'b1);
    feed(CMD_WRITE, 5'd5, 6'd6, 1'b1);
    feed(CMD_WRITE, 5'd0, 6'd0, 1'b1);
    feed(CMD_WRITE, 5'd0, 6'd1, 1'b1);
    feed(CMD_WRITE, 5'd1, 6'd0, 1'b1);
    feed(CMD_ADVANCE, 5'd0, 6'd0, 1'b0);
    feed(CMD_READ, 5'd4, 6'd5, 1'b0);
    feed(CMD_READ, 5'd5, 6'd5, 1'b0);
    feed(CMD_READ, 5'd6, 6'd5, 1'b0);
    feed(CMD_READ, 5'd5, 6'd4, 1'b0);
    feed(CMD_READ, 5'd1, 6'd1, 1'b0);
    feed(CMD_READ, 5'd19, 6'd39, 1'b0);
    feed(CMD_READ, 5'd31, 6'd63, 1'b0);
    feed(CMD_ADVANCE, 5'd31, 6'd63, 1'b1);
    feed(CMD_READ, 5'd5, 6'd4, 1'b0);
    feed(CMD_WRITE, 5'd0, 6'd0, 1'b0);
    feed(CMD_READ, 5'd0, 6'd0, 1'b1);

    // Random phases over several region sizes, the last one without idling
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        cfg_write(REG_ROWS, PDATA_W'(rows_plan[ph]));
        cfg_write(REG_COLS, PDATA_W'(cols_plan[ph]));
      end
      if (ph == 7) calm = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
    end

    drain();
    if (shadow.mismatches == 0) begin
      $display("[life_automaton_step] OK");
    end else begin
      $display("[life_automaton_step] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/life_pkg.sv
rtl/core/life_ram.sv
rtl/core/life_ctrl.sv
rtl/core/life_dpath.sv
rtl/core/life_automaton_step.sv
tb/sv/tb.sv
